### src/rgb_window_median_filter_assert.svh
// Assertion macros for the window median filter checker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWMF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("median filter check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define RWMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("median filter check failed (next cycle)");

`endif

### src/rwmf_pkg.sv
// Shared types and constants of the window median filter.
// No dependencies; used by the top level and the checker.
package rwmf_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MAX_WIN    = 9;

  localparam int unsigned PixW     = 24;
  localparam int unsigned CoordW   = 8;
  localparam int unsigned CompW    = 8;
  localparam int unsigned SpanW    = 9;
  localparam int unsigned WinCfgW  = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned FrameDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned WinDepth   = MAX_WIN * MAX_WIN;
  localparam int unsigned CntW       = $clog2(WinDepth + 1);
  localparam int unsigned WinAw      = $clog2(WinDepth);
  localparam int unsigned BitW       = $clog2(PixW);

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_WIN_WIDTH    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_WIN_HEIGHT   = CfgIdxW'(3);

  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_SELECT,
    ST_DONE
  } state_e;

endpackage

### src/rwmf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rwmf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rgb_window_median_filter.sv
// Top level of the RGB window median filter: frame store, window gather and
// bit-serial rank selection. Depends on rwmf_pkg and rwmf_ram.
//
// A store transaction writes one pixel. A compute transaction copies its
// clipped window of n pixels (n up to 81) out of the frame store into a
// window buffer, then finds the lower median one bit per pass, most
// significant bit first: each of the 24 passes reads the window buffer once
// through its single read port and counts the entries that fit the prefix
// found so far. A window that lies wholly outside the image answers zero.
// One item is worked on at a time; the result sits in an output register,
// so a stalled result does not hold back the next input. The frame store
// has no reset.
module rgb_window_median_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rwmf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rwmf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [rwmf_pkg::CoordW-1:0]   col_i,
  input  logic [rwmf_pkg::CoordW-1:0]   row_i,
  input  logic [rwmf_pkg::CompW-1:0]    red_in_i,
  input  logic [rwmf_pkg::CompW-1:0]    green_in_i,
  input  logic [rwmf_pkg::CompW-1:0]    blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rwmf_pkg::CoordW-1:0]   out_col_o,
  output logic [rwmf_pkg::CoordW-1:0]   out_row_o,
  output logic [rwmf_pkg::CompW-1:0]    red_out_o,
  output logic [rwmf_pkg::CompW-1:0]    green_out_o,
  output logic [rwmf_pkg::CompW-1:0]    blue_out_o
);

  localparam int unsigned SW = rwmf_pkg::SpanW;
  localparam int unsigned CW = rwmf_pkg::CntW;
  localparam int unsigned PW = rwmf_pkg::PixW;

  rwmf_pkg::state_e state_q, state_d;

  logic [SW-1:0] img_w_q, img_h_q;
  logic [rwmf_pkg::WinCfgW-1:0] win_w_q, win_h_q;

  logic          issue_q, issue_d;
  logic          fvld_q, svld_q;
  logic [SW-1:0] x_q, x_d, y_q, y_d, x0_q, x0_d, x1_q, x1_d, y1_q, y1_d;
  logic [CW-1:0] n_q, n_d, idx_q, idx_d, cnt_q, cnt_d, k_q, k_d;
  logic [rwmf_pkg::BitW-1:0] bit_q, bit_d;
  logic [PW-1:0] prefix_q, prefix_d;
  logic [rwmf_pkg::CoordW-1:0] qcol_q, qcol_d, qrow_q, qrow_d;
  logic          out_valid_q, out_valid_d;
  logic [rwmf_pkg::CoordW-1:0] out_col_q, out_row_q;
  logic [PW-1:0] out_pix_q;
  logic          out_load;

  logic          in_accept;
  logic          frame_re, win_re, win_we;
  logic [PW-1:0] frame_rdata, win_rdata;

  // Clamped settings and clipped window bounds of the incoming query.
  logic [SW-1:0] img_w, img_h;
  logic [rwmf_pkg::WinCfgW-1:0] win_w, win_h;
  logic [SW-1:0] cx0, cx1, cy0, cy1, ex, ey;
  logic [rwmf_pkg::WinCfgW-2:0] half_w, half_h;

  logic [PW-1:0] mask_hi;
  logic          match;
  logic [CW-1:0] cnt_tot;
  logic          pass_end;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rwmf_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == rwmf_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= SW'(rwmf_pkg::MAX_WIDTH);
      img_h_q <= SW'(rwmf_pkg::MAX_HEIGHT);
      win_w_q <= rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN);
      win_h_q <= rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwmf_pkg::CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[SW-1:0];
        rwmf_pkg::CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[SW-1:0];
        rwmf_pkg::CFG_WIN_WIDTH:    win_w_q <= cfg_data_i[rwmf_pkg::WinCfgW-1:0];
        rwmf_pkg::CFG_WIN_HEIGHT:   win_h_q <= cfg_data_i[rwmf_pkg::WinCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    img_w = (img_w_q == '0) ? SW'(1) :
            (img_w_q > SW'(rwmf_pkg::MAX_WIDTH)) ? SW'(rwmf_pkg::MAX_WIDTH) : img_w_q;
    img_h = (img_h_q == '0) ? SW'(1) :
            (img_h_q > SW'(rwmf_pkg::MAX_HEIGHT)) ? SW'(rwmf_pkg::MAX_HEIGHT) : img_h_q;
    win_w = (win_w_q == '0) ? rwmf_pkg::WinCfgW'(1) :
            (win_w_q > rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN)) ?
            rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN) : win_w_q;
    win_h = (win_h_q == '0) ? rwmf_pkg::WinCfgW'(1) :
            (win_h_q > rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN)) ?
            rwmf_pkg::WinCfgW'(rwmf_pkg::MAX_WIN) : win_h_q;
    half_w = win_w[rwmf_pkg::WinCfgW-1:1];
    half_h = win_h[rwmf_pkg::WinCfgW-1:1];
    // The window end never underflows, so only the start needs a floor at zero.
    cx0 = (col_i < rwmf_pkg::CoordW'(half_w)) ? '0 : SW'(col_i - rwmf_pkg::CoordW'(half_w));
    cy0 = (row_i < rwmf_pkg::CoordW'(half_h)) ? '0 : SW'(row_i - rwmf_pkg::CoordW'(half_h));
    ex  = SW'(col_i) + SW'(win_w - rwmf_pkg::WinCfgW'(half_w));
    ey  = SW'(row_i) + SW'(win_h - rwmf_pkg::WinCfgW'(half_h));
    cx1 = (ex > img_w) ? img_w : ex;
    cy1 = (ey > img_h) ? img_h : ey;
  end

  // Bit-serial rank test of the entry that arrives from the window buffer.
  always_comb begin
    mask_hi  = ~((PW'(2) << bit_q) - PW'(1));
    match    = (((win_rdata ^ prefix_q) & mask_hi) == '0) && !win_rdata[bit_q];
    cnt_tot  = cnt_q + CW'(match);
    pass_end = svld_q && (idx_q == n_q);
  end

  assign frame_re = (state_q == rwmf_pkg::ST_GATHER) && issue_q;
  assign win_we   = fvld_q;
  assign win_re   = (state_q == rwmf_pkg::ST_SELECT) && (idx_q != n_q);
  assign out_load = (state_q == rwmf_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    issue_d  = issue_q;
    x_d      = x_q;
    y_d      = y_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    n_d      = n_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    bit_d    = bit_q;
    prefix_d = prefix_q;
    qcol_d   = qcol_q;
    qrow_d   = qrow_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      rwmf_pkg::ST_IDLE: begin
        if (in_accept && (action_i == rwmf_pkg::ACT_COMPUTE)) begin
          qcol_d   = col_i;
          qrow_d   = row_i;
          x_d      = cx0;
          y_d      = cy0;
          x0_d     = cx0;
          x1_d     = cx1;
          y1_d     = cy1;
          n_d      = '0;
          prefix_d = '0;
          if ((cx0 >= cx1) || (cy0 >= cy1)) begin
            state_d = rwmf_pkg::ST_DONE;
          end else begin
            issue_d = 1'b1;
            state_d = rwmf_pkg::ST_GATHER;
          end
        end
      end
      rwmf_pkg::ST_GATHER: begin
        if (issue_q) begin
          if (x_q + SW'(1) == x1_q) begin
            x_d = x0_q;
            y_d = y_q + SW'(1);
            if (y_q + SW'(1) == y1_q) begin
              issue_d = 1'b0;
            end
          end else begin
            x_d = x_q + SW'(1);
          end
        end
        if (fvld_q) begin
          n_d = n_q + CW'(1);
        end
        if (!issue_q && !fvld_q) begin
          idx_d   = '0;
          cnt_d   = '0;
          bit_d   = rwmf_pkg::BitW'(PW - 1);
          k_d     = (n_q - CW'(1)) >> 1;
          state_d = rwmf_pkg::ST_SELECT;
        end
      end
      rwmf_pkg::ST_SELECT: begin
        if (win_re) begin
          idx_d = idx_q + CW'(1);
        end
        if (svld_q) begin
          cnt_d = cnt_tot;
        end
        if (pass_end) begin
          idx_d = '0;
          cnt_d = '0;
          if (k_q >= cnt_tot) begin
            k_d      = k_q - cnt_tot;
            prefix_d = prefix_q | (PW'(1) << bit_q);
          end
          if (bit_q == '0) begin
            state_d = rwmf_pkg::ST_DONE;
          end else begin
            bit_d = bit_q - rwmf_pkg::BitW'(1);
          end
        end
      end
      rwmf_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = rwmf_pkg::ST_IDLE;
        end
      end
      default: state_d = rwmf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwmf_pkg::ST_IDLE;
      issue_q     <= 1'b0;
      fvld_q      <= 1'b0;
      svld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      fvld_q      <= frame_re;
      svld_q      <= win_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    n_q      <= n_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    bit_q    <= bit_d;
    prefix_q <= prefix_d;
    qcol_q   <= qcol_d;
    qrow_q   <= qrow_d;
    if (out_load) begin
      out_col_q <= qcol_q;
      out_row_q <= qrow_q;
      out_pix_q <= prefix_q;
    end
  end

  rwmf_ram #(
    .WIDTH(PW),
    .DEPTH(rwmf_pkg::FrameDepth)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (in_accept && (action_i == rwmf_pkg::ACT_STORE)),
    .waddr_i({row_i, col_i}),
    .wdata_i({red_in_i, green_in_i, blue_in_i}),
    .re_i   (frame_re),
    .raddr_i({y_q[rwmf_pkg::CoordW-1:0], x_q[rwmf_pkg::CoordW-1:0]}),
    .rdata_o(frame_rdata)
  );

  rwmf_ram #(
    .WIDTH(PW),
    .DEPTH(rwmf_pkg::WinDepth)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(n_q[rwmf_pkg::WinAw-1:0]),
    .wdata_i(frame_rdata),
    .re_i   (win_re),
    .raddr_i(idx_q[rwmf_pkg::WinAw-1:0]),
    .rdata_o(win_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign red_out_o   = out_pix_q[PW-1 -: rwmf_pkg::CompW];
  assign green_out_o = out_pix_q[2*rwmf_pkg::CompW-1 -: rwmf_pkg::CompW];
  assign blue_out_o  = out_pix_q[rwmf_pkg::CompW-1:0];

endmodule

### src/rwmf_checker.sv
// Port-level checker for the window median filter, bound to the top level.
// Depends on rwmf_pkg and rgb_window_median_filter_assert.svh.
`include "rgb_window_median_filter_assert.svh"

module rwmf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_i,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input logic                          action_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic [rwmf_pkg::CoordW-1:0]   out_col_i,
  input logic [rwmf_pkg::CoordW-1:0]   out_row_i,
  input logic [rwmf_pkg::CompW-1:0]    red_out_i,
  input logic [rwmf_pkg::CompW-1:0]    green_out_i,
  input logic [rwmf_pkg::CompW-1:0]    blue_out_i
);

  logic store_txn, compute_txn;

  assign store_txn   = in_valid_i && !in_stall_i && (action_i == rwmf_pkg::ACT_STORE);
  assign compute_txn = in_valid_i && !in_stall_i && (action_i == rwmf_pkg::ACT_COMPUTE);

  // A held result keeps its payload.
  `RWMF_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i,
    out_valid_i && $stable(out_col_i) && $stable(out_row_i) && $stable(red_out_i) &&
    $stable(green_out_i) && $stable(blue_out_i))
  // A store leaves the block idle, so the input stays open.
  `RWMF_ASSERT_NEXT(a_store_open, store_txn, !in_stall_i)
  // A query always keeps the block busy after it is accepted.
  `RWMF_ASSERT_NEXT(a_query_busy, compute_txn, in_stall_i)
  // When a new result appears, the block is accepting input again.
  `RWMF_ASSERT_SAME(a_result_frees, $rose(out_valid_i), !in_stall_i)
  // Register writes are never held off.
  `RWMF_ASSERT_SAME(a_cfg_ready, cfg_valid_i, cfg_ready_i)

endmodule

bind rgb_window_median_filter rwmf_checker u_rwmf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_i(cfg_ready_o),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .action_i   (action_i),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_col_i  (out_col_o),
  .out_row_i  (out_row_o),
  .red_out_i  (red_out_o),
  .green_out_i(green_out_o),
  .blue_out_i (blue_out_o)
);

### verif/rgb_window_median_filter_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB window median filter: watches the three channels, predicts medians
// and compares each result transaction. Depends on rwmf_pkg.
module rgb_window_median_filter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rwmf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rwmf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          action_i,
  input  logic [rwmf_pkg::CoordW-1:0]   col_i,
  input  logic [rwmf_pkg::CoordW-1:0]   row_i,
  input  logic [rwmf_pkg::CompW-1:0]    red_in_i,
  input  logic [rwmf_pkg::CompW-1:0]    green_in_i,
  input  logic [rwmf_pkg::CompW-1:0]    blue_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [rwmf_pkg::CoordW-1:0]   out_col_i,
  input  logic [rwmf_pkg::CoordW-1:0]   out_row_i,
  input  logic [rwmf_pkg::CompW-1:0]    red_out_i,
  input  logic [rwmf_pkg::CompW-1:0]    green_out_i,
  input  logic [rwmf_pkg::CompW-1:0]    blue_out_i,
  output int                            err_count_o,
  output int                            pending_o
);

  typedef struct {
    logic [rwmf_pkg::CoordW-1:0] col;
    logic [rwmf_pkg::CoordW-1:0] row;
    logic [rwmf_pkg::PixW-1:0]   pix;
  } median_t;

  logic [rwmf_pkg::PixW-1:0]     frame [rwmf_pkg::FrameDepth];
  logic [rwmf_pkg::CfgDataW-1:0] img_w, img_h;
  logic [rwmf_pkg::WinCfgW-1:0]  win_w, win_h;
  median_t                       median_q[$];

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [rwmf_pkg::PixW-1:0] window_median(int c, int r);
    int x0, x1, y0, y1, n, i, j, ww, wh, iw, ih;
    logic [rwmf_pkg::PixW-1:0] vals [rwmf_pkg::WinDepth];
    logic [rwmf_pkg::PixW-1:0] t;
    ww = sat(int'(win_w), int'(rwmf_pkg::MAX_WIN));
    wh = sat(int'(win_h), int'(rwmf_pkg::MAX_WIN));
    iw = sat(int'(img_w), int'(rwmf_pkg::MAX_WIDTH));
    ih = sat(int'(img_h), int'(rwmf_pkg::MAX_HEIGHT));
    x0 = c - ww / 2;
    x1 = x0 + ww;
    y0 = r - wh / 2;
    y1 = y0 + wh;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > iw) x1 = iw;
    if (y1 > ih) y1 = ih;
    n = 0;
    for (int y = y0; y < y1; y++) begin
      for (int x = x0; x < x1; x++) begin
        vals[n] = frame[y * int'(rwmf_pkg::MAX_WIDTH) + x];
        n++;
      end
    end
    if (n == 0) return '0;
    for (i = 1; i < n; i++) begin
      t = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > t) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = t;
    end
    return vals[(n - 1) / 2];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    median_t m;
    if (!rst_ni) begin
      img_w = 9'd256;
      img_h = 9'd256;
      win_w = 4'd9;
      win_h = 4'd9;
      median_q.delete();
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rwmf_pkg::CFG_IMAGE_WIDTH:  img_w = cfg_data_i;
          rwmf_pkg::CFG_IMAGE_HEIGHT: img_h = cfg_data_i;
          rwmf_pkg::CFG_WIN_WIDTH:    win_w = cfg_data_i[rwmf_pkg::WinCfgW-1:0];
          rwmf_pkg::CFG_WIN_HEIGHT:   win_h = cfg_data_i[rwmf_pkg::WinCfgW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == rwmf_pkg::ACT_STORE) begin
          frame[{row_i, col_i}] = {red_in_i, green_in_i, blue_in_i};
        end else begin
          m.col = col_i;
          m.row = row_i;
          m.pix = window_median(int'(col_i), int'(row_i));
          median_q.push_back(m);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (median_q.size() == 0) begin
          $error("result transaction with no query outstanding");
          err_count_o <= err_count_o + 1;
        end else begin
          m = median_q.pop_front();
          if (out_col_i !== m.col || out_row_i !== m.row || red_out_i !== m.pix[23:16] ||
              green_out_i !== m.pix[15:8] || blue_out_i !== m.pix[7:0]) begin
            err_count_o <= err_count_o + 1;
          end
          if (out_col_i !== m.col)
            $error("out_col expected %0d actual %0d", m.col, out_col_i);
          if (out_row_i !== m.row)
            $error("out_row expected %0d actual %0d", m.row, out_row_i);
          if (red_out_i !== m.pix[23:16])
            $error("red_out expected %0h actual %0h", m.pix[23:16], red_out_i);
          if (green_out_i !== m.pix[15:8])
            $error("green_out expected %0h actual %0h", m.pix[15:8], green_out_i);
          if (blue_out_i !== m.pix[7:0])
            $error("blue_out expected %0h actual %0h", m.pix[7:0], blue_out_i);
        end
      end
      pending_o <= median_q.size();
    end
  end

endmodule

### verif/rgb_window_median_filter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB window median filter: clock, reset, stimulus and verdict.
// Depends on rwmf_pkg, rgb_window_median_filter and rgb_window_median_filter_checker.
module rgb_window_median_filter_tb;

  localparam int WatchLimit = 20000;
  localparam int PhaseItems = 10;

  logic                          clk_i, rst_ni;
  logic                          cfg_valid_i, cfg_ready_o;
  logic [rwmf_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [rwmf_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i, in_stall_o, action_i;
  logic [rwmf_pkg::CoordW-1:0]   col_i, row_i, out_col_o, out_row_o;
  logic [rwmf_pkg::CompW-1:0]    red_in_i, green_in_i, blue_in_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [rwmf_pkg::CompW-1:0]    red_out_o, green_out_o, blue_out_o;
  int                            err_count, pending;

  int  send_idle_pct, recv_stall_pct;
  int  idle_cycles = 0;
  int  n_stores, n_queries, phase_items, n_phases;
  int  cur_w, cur_h, cur_ww, cur_wh;
  bit  written [rwmf_pkg::FrameDepth];

  rgb_window_median_filter DUT (.*);

  rgb_window_median_filter_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .col_i, .row_i, .red_in_i,
    .green_in_i, .blue_in_i, .out_valid_i(out_valid_o), .out_stall_i, .out_col_i(out_col_o),
    .out_row_i(out_row_o), .red_out_i(red_out_o), .green_out_i(green_out_o),
    .blue_out_i(blue_out_o), .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Any accepted transaction on any channel restarts the watchdog.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("rgb_window_median_filter_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int clip(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic logic [rwmf_pkg::PixW-1:0] random_pixel();
    // Half of the pixels come from a tiny palette so that windows hold ties.
    if ($urandom_range(1)) return {8'($urandom_range(2) * 8'h7f), 8'h40, 8'h00};
    return rwmf_pkg::PixW'($urandom);
  endfunction

  task automatic send_item(logic act, int c, int r, logic [rwmf_pkg::PixW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    col_i      <= rwmf_pkg::CoordW'(c);
    row_i      <= rwmf_pkg::CoordW'(r);
    {red_in_i, green_in_i, blue_in_i} <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    phase_items++;
    if (act == rwmf_pkg::ACT_STORE) begin
      written[r * int'(rwmf_pkg::MAX_WIDTH) + c] = 1'b1;
      n_stores++;
    end else begin
      n_queries++;
    end
  endtask

  // Stores every pixel of the clipped window that was never written, then queries.
  task automatic query(int c, int r);
    int x0, x1, y0, y1, ww, wh, iw, ih;
    ww = clip(cur_ww, int'(rwmf_pkg::MAX_WIN));
    wh = clip(cur_wh, int'(rwmf_pkg::MAX_WIN));
    iw = clip(cur_w, int'(rwmf_pkg::MAX_WIDTH));
    ih = clip(cur_h, int'(rwmf_pkg::MAX_HEIGHT));
    x0 = c - ww / 2;
    y0 = r - wh / 2;
    x1 = x0 + ww;
    y1 = y0 + wh;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > iw) x1 = iw;
    if (y1 > ih) y1 = ih;
    for (int y = y0; y < y1; y++)
      for (int x = x0; x < x1; x++)
        if (!written[y * int'(rwmf_pkg::MAX_WIDTH) + x])
          send_item(rwmf_pkg::ACT_STORE, x, y, random_pixel());
    send_item(rwmf_pkg::ACT_COMPUTE, c, r, rwmf_pkg::PixW'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rwmf_pkg::CfgIdxW-1:0] idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= rwmf_pkg::CfgDataW'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      rwmf_pkg::CFG_IMAGE_WIDTH:  cur_w  = val & 9'h1ff;
      rwmf_pkg::CFG_IMAGE_HEIGHT: cur_h  = val & 9'h1ff;
      rwmf_pkg::CFG_WIN_WIDTH:    cur_ww = val & 4'hf;
      rwmf_pkg::CFG_WIN_HEIGHT:   cur_wh = val & 4'hf;
      default: ;
    endcase
  endtask

  initial begin
    int settings [7][4];
    int c, r, span_c, span_r;
    settings = '{
      '{1, 1, 1, 1}, '{0, 0, 0, 0}, '{16, 12, 3, 5}, '{511, 300, 15, 9},
      '{40, 3, 2, 8}, '{5, 70, 9, 4}, '{256, 256, 7, 6}};
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; action_i = rwmf_pkg::ACT_STORE; col_i = '0; row_i = '0;
    red_in_i = '0; green_in_i = '0; blue_in_i = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_stores = 0; n_queries = 0; n_phases = 0;
    cur_w = 256; cur_h = 256; cur_ww = 9; cur_wh = 9;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: corners, full window, extreme pixels.
    send_item(rwmf_pkg::ACT_STORE, 0, 0, 24'h000000);
    send_item(rwmf_pkg::ACT_STORE, 255, 255, 24'hffffff);
    send_item(rwmf_pkg::ACT_STORE, 254, 255, 24'hffffff);
    query(0, 0);
    query(255, 255);
    query(128, 128);
    drain();

    foreach (settings[p]) begin
      write_reg(rwmf_pkg::CFG_IMAGE_WIDTH, settings[p][0]);
      write_reg(rwmf_pkg::CFG_IMAGE_HEIGHT, settings[p][1]);
      write_reg(rwmf_pkg::CFG_WIN_WIDTH, settings[p][2]);
      write_reg(rwmf_pkg::CFG_WIN_HEIGHT, settings[p][3]);
      if (p == 1) begin
        // Writes to indexes past the last register must be ignored.
        write_reg(rwmf_pkg::CfgIdxW'(4), 9'h1ff);
        write_reg(rwmf_pkg::CfgIdxW'(255), 9'h000);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      span_c = clip(cur_w, 32) + 6;
      span_r = clip(cur_h, 32) + 6;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if ($urandom_range(9) < 2) begin
          c = $urandom_range(255);
          r = $urandom_range(255);
          send_item(rwmf_pkg::ACT_STORE, c, r, random_pixel());
        end else begin
          // Mostly near the origin; positions past the image can give empty windows.
          c = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(span_c);
          r = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(span_r);
          query(c, r);
        end
      end
      drain();
      n_phases++;
    end

    $display("Covered %0d settings phases with %0d pixel stores and %0d median queries,",
             n_phases + 1, n_stores, n_queries);
    $display("under no idling, sender gaps, result stalls and both together.");
    if (err_count == 0 && pending == 0) begin
      $display("rgb_window_median_filter_tb: PASS");
    end else begin
      $display("rgb_window_median_filter_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rwmf_pkg.sv
src/rwmf_ram.sv
src/rgb_window_median_filter.sv
src/rwmf_checker.sv
verif/rgb_window_median_filter_checker.sv
verif/rgb_window_median_filter_tb.sv
